// ===== hdl/lfmd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfmd_pkg
// shared types and constants for the linear fit / max deviation block
// ----------------------------------------------------------------------------
package lfmd_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 1024;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RES_W = 48;
  localparam int unsigned CNT_OUT_W = 11;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;
  localparam logic [1:0] ST_DROP = 2'd3;

  localparam logic signed [RES_W-1:0] SMAX48 = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] SMIN48 = {1'b1, {(RES_W-1){1'b0}}};
  localparam logic [RES_W-1:0] UMAX48 = {RES_W{1'b1}};

  // one queue entry between front and back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic last;
  } sample_t;

endpackage

// ===== hdl/lfmd_if.sv =====
// ----------------------------------------------------------------------------
// lfmd_in_if / lfmd_out_if
// valid/ready channels for samples and fit results
// ----------------------------------------------------------------------------
interface lfmd_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] x_value;
  logic signed [15:0] y_value;
  logic last_sample;
  modport source(output valid, x_value, y_value, last_sample, input ready);
  modport sink(input valid, x_value, y_value, last_sample, output ready);
endinterface

interface lfmd_out_if;
  logic valid;
  logic ready;
  logic signed [47:0] intercept;
  logic signed [47:0] slope;
  logic [47:0] max_deviation;
  logic [10:0] sample_count;
  logic [1:0] fit_status;
  modport source(output valid, intercept, slope, max_deviation, sample_count, fit_status,
                 input ready);
  modport sink(input valid, intercept, slope, max_deviation, sample_count, fit_status,
               output ready);
endinterface

// ===== hdl/lfmd_front.sv =====
// ----------------------------------------------------------------------------
// lfmd_front
// accepts samples and pushes them into a short queue for the back end
// ----------------------------------------------------------------------------
module lfmd_front (
  input  logic clk,
  input  logic rst_n,
  lfmd_in_if.sink in_ch,
  output lfmd_pkg::sample_t q_data,
  output logic q_valid,
  input  logic q_pop
);
  import lfmd_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  sample_t mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0] cnt_r;
  logic push;

  assign in_ch.ready = (cnt_r != (PW+1)'(QUEUE_DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != '0);
  assign q_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{x: in_ch.x_value, y: in_ch.y_value, last: in_ch.last_sample};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end
endmodule

// ===== hdl/lfmd_back.sv =====
// ----------------------------------------------------------------------------
// lfmd_back
// accumulates sums, stores samples, fits the line and walks the residuals
// ----------------------------------------------------------------------------
module lfmd_back #(
  parameter int unsigned MAX_SAMPLES = lfmd_pkg::MAX_SAMPLES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  lfmd_pkg::sample_t q_data,
  input  logic q_valid,
  output logic q_pop,
  lfmd_out_if.source out_ch
);
  import lfmd_pkg::*;

  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SXW = CW + 16;
  localparam int unsigned SQW = CW + 31;
  localparam int unsigned PW = 2 * SQW + 4;   // product / numerator width
  localparam int unsigned NW = PW + 16;       // shifted numerator width
  localparam int unsigned RW = RES_W + 18;    // residual width

  localparam logic [3:0] S_ACC = 4'd0, S_M1 = 4'd1, S_M2 = 4'd2, S_M3 = 4'd3,
                         S_M4 = 4'd4, S_DIV = 4'd5, S_DV2 = 4'd6, S_FIN = 4'd7,
                         S_WALK = 4'd8, S_WW = 4'd9, S_OUT = 4'd10, S_MW = 4'd11;

  logic [3:0] st_r, ret_r;
  logic signed [15:0] xs_mem [MAX_SAMPLES];
  logic signed [15:0] ys_mem [MAX_SAMPLES];
  logic signed [15:0] xr_r, yr_r, yd_r;
  logic signed [SXW-1:0] sx_r, sy_r;
  logic signed [SQW-1:0] sxx_r, sxy_r;
  logic [CW-1:0] cnt_r, idx_r;
  logic drop_r, sat_r, degen_r;
  logic signed [PW-1:0] p1_r, d_r, nb_r, na_r;
  logic [NW-1:0] dvd_r, quo_r;
  logic [PW-1:0] rem_r, dvs_r;
  logic neg_r, sel_r;
  logic [$clog2(NW+1)-1:0] bit_r;
  logic signed [RES_W-1:0] a_r, b_r;
  logic [RW-1:0] best_r;
  logic signed [RES_W+17:0] bx_r;
  logic signed [RW-1:0] res_r;
  logic rv_r, rd_r, walk_on_r;

  // registered multiplier operands, shift-and-add over the magnitudes
  logic signed [PW-1:0] ma_r, mb_r;
  logic [PW-1:0] mc_r, macc_r;
  logic [SQW-1:0] mq_r;
  logic [$clog2(SQW+1)-1:0] mcnt_r;
  logic mneg_r, mbusy_r;
  logic signed [PW-1:0] prod;
  assign prod = mneg_r ? -$signed(macc_r) : $signed(macc_r);

  assign q_pop = (st_r == S_ACC) && q_valid;

  logic full;
  assign full = (cnt_r == CW'(MAX_SAMPLES));

  always_ff @(posedge clk) begin
    if (q_pop && !full) begin
      xs_mem[cnt_r[AW-1:0]] <= q_data.x;
      ys_mem[cnt_r[AW-1:0]] <= q_data.y;
    end
    xr_r <= xs_mem[idx_r[AW-1:0]];
    yr_r <= ys_mem[idx_r[AW-1:0]];
  end

  // restoring divider step
  logic [PW:0] rsh;
  assign rsh = {rem_r, dvd_r[NW-1]};

  logic [NW-1:0] qmag;
  logic signed [RES_W-1:0] qsat;
  logic qs;
  always_comb begin
    qmag = quo_r;
    qs = 1'b0;
    if (neg_r) begin
      if (qmag > NW'(SMAX48) + 1'b1) begin qsat = SMIN48; qs = 1'b1; end
      else qsat = RES_W'(-$signed({1'b0, qmag}));
    end else begin
      if (qmag > NW'(SMAX48)) begin qsat = SMAX48; qs = 1'b1; end
      else qsat = RES_W'(qmag);
    end
  end

  logic [RW-1:0] rmag;
  assign rmag = res_r[RW-1] ? RW'(-res_r) : res_r;

  logic dev_ovf;
  assign dev_ovf = |best_r[RW-1:RES_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_ACC;
      sx_r <= '0; sy_r <= '0; sxx_r <= '0; sxy_r <= '0;
      cnt_r <= '0; drop_r <= 1'b0; sat_r <= 1'b0; degen_r <= 1'b0;
      out_ch.valid <= 1'b0; rv_r <= 1'b0; rd_r <= 1'b0; walk_on_r <= 1'b0;
      sel_r <= 1'b0; bit_r <= '0; idx_r <= '0; best_r <= '0; mbusy_r <= 1'b0;
    end else begin
      case (st_r)
        S_ACC: begin
          if (q_pop) begin
            if (!full) begin
              cnt_r <= cnt_r + 1'b1;
              sx_r <= sx_r + SXW'(q_data.x);
              sy_r <= sy_r + SXW'(q_data.y);
              sxx_r <= sxx_r + SQW'(q_data.x * q_data.x);
              sxy_r <= sxy_r + SQW'(q_data.x * q_data.y);
            end else drop_r <= 1'b1;
            if (q_data.last) begin
              ma_r <= PW'($signed({1'b0, cnt_r + CW'(!full)}));
              mb_r <= PW'(sxx_r + (full ? '0 : SQW'(q_data.x * q_data.x)));
              ret_r <= S_M1; st_r <= S_MW;
            end
          end
        end
        // one product: load magnitudes, SQW add/shift steps, then return
        S_MW: begin
          if (!mbusy_r) begin
            mneg_r <= ma_r[PW-1] ^ mb_r[PW-1];
            mc_r <= ma_r[PW-1] ? -ma_r : ma_r;
            mq_r <= SQW'(mb_r[PW-1] ? -mb_r : mb_r);
            macc_r <= '0;
            mcnt_r <= ($clog2(SQW+1))'(SQW);
            mbusy_r <= 1'b1;
          end else if (mcnt_r != '0) begin
            if (mq_r[0]) macc_r <= macc_r + mc_r;
            mc_r <= mc_r << 1;
            mq_r <= mq_r >> 1;
            mcnt_r <= mcnt_r - 1'b1;
          end else begin
            mbusy_r <= 1'b0; st_r <= ret_r;
          end
        end
        // products are formed one at a time through the shared multiplier
        S_M1: begin
          p1_r <= prod; ma_r <= PW'(sx_r); mb_r <= PW'(sx_r);
          ret_r <= S_M2; st_r <= S_MW;
        end
        S_M2: begin
          d_r <= p1_r - prod;
          ma_r <= PW'($signed({1'b0, cnt_r})); mb_r <= PW'(sxy_r);
          ret_r <= S_M3; st_r <= S_MW;
        end
        S_M3: begin
          p1_r <= prod; ma_r <= PW'(sx_r);
          mb_r <= sel_r ? PW'(sxy_r) : PW'(sy_r);
          ret_r <= S_M4; st_r <= S_MW;
          degen_r <= (d_r == '0);
        end
        S_M4: begin
          if (!sel_r) begin
            nb_r <= p1_r - prod;
            ma_r <= PW'(sy_r); mb_r <= PW'(sxx_r); sel_r <= 1'b1;
            ret_r <= S_M3; st_r <= S_MW;
          end else begin
            // na = sy*sxx - sx*sxy
            na_r <= p1_r - prod; sel_r <= 1'b0; st_r <= S_DIV;
          end
        end
        S_DIV: begin
          // load first division (slope, or sy/n if degenerate)
          if (degen_r) begin
            neg_r <= sy_r[SXW-1];
            dvd_r <= NW'(sy_r[SXW-1] ? -({{(NW-SXW){sy_r[SXW-1]}}, sy_r} <<< 16)
                                     : ({{(NW-SXW){1'b0}}, sy_r} << 16));
            dvs_r <= PW'(cnt_r);
          end else begin
            neg_r <= nb_r[PW-1];
            dvd_r <= NW'(nb_r[PW-1] ? -({{16{nb_r[PW-1]}}, nb_r} <<< 16)
                                    : ({16'b0, nb_r} << 16));
            dvs_r <= d_r;
          end
          rem_r <= '0; quo_r <= '0; bit_r <= ($clog2(NW+1))'(NW); st_r <= S_DV2;
        end
        S_DV2: begin
          if (bit_r != '0) begin
            bit_r <= bit_r - 1'b1;
            dvd_r <= dvd_r << 1;
            if (rsh >= {1'b0, dvs_r}) begin
              rem_r <= PW'(rsh - {1'b0, dvs_r}); quo_r <= {quo_r[NW-2:0], 1'b1};
            end else begin
              rem_r <= PW'(rsh); quo_r <= {quo_r[NW-2:0], 1'b0};
            end
          end else st_r <= S_FIN;
        end
        S_FIN: begin
          if (degen_r) begin
            a_r <= qsat; b_r <= '0; st_r <= S_WALK;
          end else if (!sel_r) begin
            b_r <= qsat; sat_r <= sat_r | qs; sel_r <= 1'b1;
            neg_r <= na_r[PW-1];
            dvd_r <= NW'(na_r[PW-1] ? -({{16{na_r[PW-1]}}, na_r} <<< 16)
                                    : ({16'b0, na_r} << 16));
            rem_r <= '0; quo_r <= '0; bit_r <= ($clog2(NW+1))'(NW); st_r <= S_DV2;
          end else begin
            a_r <= qsat; sat_r <= sat_r | qs; sel_r <= 1'b0; st_r <= S_WALK;
          end
          idx_r <= '0; best_r <= '0; rv_r <= 1'b0; rd_r <= 1'b0;
        end
        // walk: address, read, product, residual, compare
        S_WALK: begin
          if (idx_r != cnt_r) idx_r <= idx_r + 1'b1;
          rv_r <= (idx_r != cnt_r);
          rd_r <= rv_r;
          if (rv_r) begin
            bx_r <= b_r * xr_r;
            yd_r <= yr_r;
          end
          walk_on_r <= rd_r;
          if (rd_r) res_r <= RW'($signed({yd_r, 16'b0})) - RW'(a_r) - bx_r;
          if (walk_on_r && rmag > best_r) best_r <= rmag;
          if (!rv_r && !rd_r && !walk_on_r && idx_r == cnt_r) st_r <= S_WW;
        end
        S_WW: begin
          out_ch.valid <= 1'b1;
          out_ch.intercept <= a_r;
          out_ch.slope <= b_r;
          out_ch.max_deviation <= dev_ovf ? UMAX48 : best_r[RES_W-1:0];
          out_ch.sample_count <= CNT_OUT_W'(cnt_r);
          out_ch.fit_status <= degen_r ? ST_DEGEN : drop_r ? ST_DROP :
                               (sat_r || dev_ovf) ? ST_SAT : ST_OK;
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            sx_r <= '0; sy_r <= '0; sxx_r <= '0; sxy_r <= '0;
            cnt_r <= '0; drop_r <= 1'b0; sat_r <= 1'b0; st_r <= S_ACC;
          end
        end
        default: st_r <= S_ACC;
      endcase
    end
  end
endmodule

// ===== hdl/linear_fit_max_deviation.sv =====
// ----------------------------------------------------------------------------
// linear_fit_max_deviation
// least-squares line fit with largest absolute residual
// ----------------------------------------------------------------------------
// Samples are taken one per cycle into a two-entry queue and accumulated into
// running sums and a sample memory. A sample marked last starts the fit: six
// products on one shift-and-add multiplier, one after another, then one or two
// restoring divisions, then a walk over the stored samples at one per cycle
// through an address, read, product, residual and compare pipeline. While the
// fit runs the input stalls once the queue holds two samples. The result is
// held until taken; the block then clears its sums and count.
module linear_fit_max_deviation #(
  parameter int unsigned MAX_SAMPLES = lfmd_pkg::MAX_SAMPLES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lfmd_in_if.sink in_ch,
  lfmd_out_if.source out_ch
);
  import lfmd_pkg::*;

  sample_t q_data;
  logic q_valid, q_pop;

  lfmd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  lfmd_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_data(q_data), .q_valid(q_valid),
    .q_pop(q_pop), .out_ch(out_ch)
  );
endmodule
